// ===== src/lkvc_pkg.sv =====
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [CAP_W-1:0]        cap_t;

    typedef enum logic
    {
        ACT_GET = 1'b0,
        ACT_SET = 1'b1
    } action_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // Sequencer to datapath
    typedef struct packed
    {
        logic in_ready;
        logic scan;
        logic scan_step;
        logic fetch;
        logic upd_step;
        logic load;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed
    {
        logic upd_needed;
        logic out_free;
    } sts_t;

    typedef struct packed
    {
        logic key_eq;
        logic rank_gt;
        logic rank_lt;
    } cmp_t;

endpackage

// ===== src/lkvc_if.sv =====
`timescale 1ns / 1ps

interface lkvc_req_if;
    import lkvc_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    key_t    key;
    val_t    value;

    modport source (output valid, action, key, value, input ready);
    modport sink (input valid, action, key, value, output ready);
endinterface

interface lkvc_rsp_if;
    import lkvc_pkg::*;

    logic valid;
    logic ready;
    logic found;
    val_t read_value;

    modport source (output valid, found, read_value, input ready);
    modport sink (input valid, found, read_value, output ready);
endinterface

// ===== src/lkvc_ram.sv =====
`timescale 1ns / 1ps

module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lkvc_cmp_unit.sv =====
`timescale 1ns / 1ps

module lkvc_cmp_unit #(
    parameter int RW = 4
) (
    input  lkvc_pkg::key_t    key_a,
    input  lkvc_pkg::key_t    key_b,
    input  logic [RW-1:0]     rank,
    input  logic [RW-1:0]     ref_rank,
    output lkvc_pkg::cmp_t    res,
    output logic [RW-1:0]     rank_inc
);
    import lkvc_pkg::*;

    // Keys compare as raw bits
    always_comb
    begin
        res.key_eq  = (key_a == key_b);
        res.rank_gt = (rank > ref_rank);
        res.rank_lt = (rank < ref_rank);
        rank_inc    = rank + RW'(1);
    end

endmodule

// ===== src/lkvc_seq.sv =====
`timescale 1ns / 1ps

module lkvc_seq #(
    parameter int ENTRIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_fire,
    input  lkvc_pkg::sts_t                  sts,
    output lkvc_pkg::ctrl_t                 ctrl,
    output logic [$clog2(ENTRIES+1)-1:0]    cnt
);
    import lkvc_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            last;

    assign last = (cnt_reg == CW'(ENTRIES));
    assign cnt  = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = sts.upd_needed ? ST_UPDATE : ST_FINISH;
            end
            ST_UPDATE:
            begin
                if (last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        cnt_next = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                ctrl.scan      = 1'b1;
                ctrl.scan_step = (cnt_reg != '0);
                cnt_next       = cnt_reg + CW'(1);
            end
            ST_FETCH:
            begin
                ctrl.fetch = 1'b1;
            end
            ST_UPDATE:
            begin
                ctrl.upd_step = (cnt_reg != '0);
                cnt_next      = cnt_reg + CW'(1);
            end
            ST_FINISH:
            begin
                ctrl.load = sts.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// ===== src/lru_key_value_cache.sv =====
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// Each request is a get or a set; each gives exactly one response with found
// and, for a get hit, the stored value (zero otherwise). The block handles one
// request at a time: a scan reads one entry per cycle from the key and rank
// memories through a single compare unit, then a second pass rewrites the
// recency ranks one entry per cycle. A get miss skips the rank pass. The
// response sits in an output register and a new request is taken while it
// waits. Valid bits are flops cleared by reset, so no clearing pass runs.
// Write capacity only while idle; 0 acts as 1, values above ENTRIES as ENTRIES.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  lkvc_pkg::cap_t       cfg_wr_data,
    lkvc_req_if.sink             req,
    lkvc_rsp_if.source           rsp
);
    import lkvc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(ENTRIES + 1);

    ctrl_t          ctrl;
    sts_t           sts;
    cmp_t           cmp;
    logic [CW-1:0]  cnt;
    logic [CW-1:0]  cnt_dec;
    logic [IW-1:0]  jdx;
    logic           in_fire;

    // Request payload
    action_t        act_reg;
    key_t           key_reg;
    val_t           val_reg;

    // Scan results
    logic           hit_reg;
    logic [IW-1:0]  hit_idx_reg;
    logic [RW-1:0]  hit_rank_reg;
    logic           vic_found_reg;
    logic [IW-1:0]  vic_idx_reg;
    logic [RW-1:0]  vic_rank_reg;
    logic           free_found_reg;
    logic [IW-1:0]  free_idx_reg;

    // Update plan
    logic [IW-1:0]  tgt_reg, tgt_next;
    logic           ins_reg, ins_next;

    logic [ENTRIES-1:0] valid_reg;
    logic [CW-1:0]      live_reg;
    cap_t               cap_reg;
    logic [CW-1:0]      eff_cap;

    logic           rsp_valid_reg;
    logic           rsp_found_reg;
    val_t           rsp_value_reg;

    logic [KEY_W-1:0] key_rd;
    logic [VAL_W-1:0] val_rd;
    logic [RW-1:0]    rank_rd;
    logic             rank_we;
    logic [RW-1:0]    rank_wd;
    logic [RW-1:0]    rank_wd_inc;
    logic [RW-1:0]    ref_rank;

    logic           evict;
    logic [IW-1:0]  slot;
    logic           slot_ok;

    assign in_fire   = req.valid && req.ready;
    assign req.ready = ctrl.in_ready;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = rsp_found_reg;
    assign rsp.read_value = rsp_value_reg;

    assign sts.out_free   = !rsp_valid_reg || rsp.ready;
    assign sts.upd_needed = hit_reg || ins_next;

    // Data returned this cycle belongs to the entry addressed last cycle
    assign cnt_dec = cnt - CW'(1);
    assign jdx     = cnt_dec[IW-1:0];

    lkvc_seq #(
        .ENTRIES (ENTRIES)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .sts     (sts),
        .ctrl    (ctrl),
        .cnt     (cnt)
    );

    lkvc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (ctrl.load && ins_reg),
        .waddr (tgt_reg),
        .wdata (key_reg),
        .raddr (cnt[IW-1:0]),
        .rdata (key_rd)
    );

    lkvc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk   (clk),
        .we    (ctrl.load && (act_reg == ACT_SET) && (hit_reg || ins_reg)),
        .waddr (tgt_reg),
        .wdata (val_reg),
        .raddr (hit_idx_reg),
        .rdata (val_rd)
    );

    lkvc_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES)
    ) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (jdx),
        .wdata (rank_wd),
        .raddr (cnt[IW-1:0]),
        .rdata (rank_rd)
    );

    assign ref_rank = ctrl.scan ? vic_rank_reg : hit_rank_reg;

    lkvc_cmp_unit #(
        .RW (RW)
    ) u_cmp (
        .key_a    (key_t'(key_rd)),
        .key_b    (key_reg),
        .rank     (rank_rd),
        .ref_rank (ref_rank),
        .res      (cmp),
        .rank_inc (rank_wd_inc)
    );

    // Rank pass: target goes to zero, others age when younger than the hit
    // (touch) or always (insert)
    always_comb
    begin
        rank_we = 1'b0;
        rank_wd = rank_wd_inc;
        if (ctrl.upd_step)
        begin
            if (jdx == tgt_reg)
            begin
                rank_we = 1'b1;
                rank_wd = '0;
            end
            else if (valid_reg[jdx] && (ins_reg || cmp.rank_lt))
            begin
                rank_we = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (32'(cap_reg) > 32'(ENTRIES))
        begin
            eff_cap = CW'(ENTRIES);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    // Plan after the scan: evict the oldest entry on a full set miss, then
    // take the lowest free slot
    always_comb
    begin
        evict = (act_reg == ACT_SET) && !hit_reg && (live_reg >= eff_cap)
                && (live_reg != '0) && vic_found_reg;
        if (evict)
        begin
            slot    = (free_found_reg && (free_idx_reg < vic_idx_reg)) ? free_idx_reg
                                                                       : vic_idx_reg;
            slot_ok = 1'b1;
        end
        else
        begin
            slot    = free_idx_reg;
            slot_ok = free_found_reg;
        end
        ins_next = (act_reg == ACT_SET) && !hit_reg && slot_ok;
        tgt_next = hit_reg ? hit_idx_reg : slot;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= req.action;
            key_reg <= req.key;
            val_reg <= req.value;
        end
        if (ctrl.scan_step)
        begin
            if (valid_reg[jdx] && cmp.key_eq && !hit_reg)
            begin
                hit_idx_reg  <= jdx;
                hit_rank_reg <= rank_rd;
            end
            if (valid_reg[jdx] && (!vic_found_reg || cmp.rank_gt))
            begin
                vic_idx_reg  <= jdx;
                vic_rank_reg <= rank_rd;
            end
            if (!valid_reg[jdx] && !free_found_reg)
            begin
                free_idx_reg <= jdx;
            end
        end
        if (ctrl.fetch)
        begin
            tgt_reg <= tgt_next;
        end
        if (ctrl.load)
        begin
            rsp_found_reg <= hit_reg;
            rsp_value_reg <= ((act_reg == ACT_GET) && hit_reg) ? val_t'(val_rd) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            vic_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            ins_reg        <= 1'b0;
            valid_reg      <= '0;
            live_reg       <= '0;
            cap_reg        <= CAP_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                hit_reg        <= 1'b0;
                vic_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (ctrl.scan_step)
            begin
                if (valid_reg[jdx] && cmp.key_eq)
                begin
                    hit_reg <= 1'b1;
                end
                if (valid_reg[jdx])
                begin
                    vic_found_reg <= 1'b1;
                end
                if (!valid_reg[jdx])
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (ctrl.fetch)
            begin
                ins_reg <= ins_next;
                if (evict)
                begin
                    valid_reg[vic_idx_reg] <= 1'b0;
                    live_reg               <= live_reg - CW'(1);
                end
            end
            if (ctrl.load && ins_reg)
            begin
                valid_reg[tgt_reg] <= 1'b1;
                live_reg           <= live_reg + CW'(1);
            end
            if (ctrl.load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) <= 32'(ENTRIES))
        else $error("live count exceeds entry count");

    a_live_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(live_reg))
        else $error("live count disagrees with valid bits");

    a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load && ins_reg |-> !valid_reg[tgt_reg])
        else $error("insert into an occupied slot");

    a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fetch && hit_reg |-> valid_reg[hit_idx_reg])
        else $error("hit on an invalid entry");
`endif

endmodule

// ===== tb/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int ENTRIES       = 16;
    localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int MAX_PRINTED   = 40;
    localparam int POOL_MAX      = 24;
    localparam int PHASE_ITEMS   = 210;

    localparam key_t KEY_MIN = 32'sh8000_0000;
    localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
    localparam val_t VAL_MIN = 32'sh8000_0000;
    localparam val_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam cap_t CAP_TOP = 5'd31;

    typedef struct packed
    {
        logic found;
        val_t read_value;
    } lookup_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    cap_t cfg_wr_data;

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();

    lru_key_value_cache #(
        .ENTRIES (ENTRIES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Shadow copy of the cache contents
    key_t    slot_key  [ENTRIES];
    val_t    slot_val  [ENTRIES];
    bit      slot_live [ENTRIES];
    int      slot_age  [ENTRIES];
    int      live_count  = 0;
    cap_t    cap_setting = CAP_RESET;

    lookup_t pending_q [$];
    int      error_count = 0;
    bit      idle_on     = 1'b1;
    int      rsp_hold    = 0;
    key_t    key_pool [POOL_MAX];
    int      pool_size   = 1;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_lru_key_value_cache: FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // Make slot s the most recent; younger entries age by one.
    function automatic void promote(input int s);
        int r;
        int i;
        r = slot_age[s];
        for (i = 0; i < ENTRIES; i++)
            if (slot_live[i] && slot_age[i] < r)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic lookup_t predict_access(input action_t act, input key_t k,
                                               input val_t v);
        lookup_t res;
        int      hit;
        int      victim;
        int      free_slot;
        int      room;
        int      i;
        hit       = -1;
        victim    = -1;
        free_slot = -1;
        for (i = 0; i < ENTRIES; i++)
            if (hit < 0 && slot_live[i] && slot_key[i] == k)
                hit = i;
        res.found      = (hit >= 0);
        res.read_value = '0;
        if (hit >= 0)
        begin
            if (act == ACT_GET)
                res.read_value = slot_val[hit];
            else
                slot_val[hit] = v;
            promote(hit);
            return res;
        end
        if (act == ACT_GET)
            return res;

        // Zero acts as one, anything above the array size saturates.
        room = (cap_setting == 0) ? 1 : (cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting);
        if (live_count >= room && live_count > 0)
        begin
            for (i = 0; i < ENTRIES; i++)
                if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                    victim = i;
            if (victim >= 0)
            begin
                slot_live[victim] = 1'b0;
                live_count--;
            end
        end
        for (i = ENTRIES - 1; i >= 0; i--)
            if (!slot_live[i])
                free_slot = i;
        if (free_slot >= 0)
        begin
            for (i = 0; i < ENTRIES; i++)
                if (slot_live[i])
                    slot_age[i]++;
            slot_live[free_slot] = 1'b1;
            slot_key[free_slot]  = k;
            slot_val[free_slot]  = v;
            slot_age[free_slot]  = 0;
            live_count++;
        end
        return res;
    endfunction

    function automatic key_t pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, pool_size - 1)];
        return key_t'($urandom);
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("%0t ERROR: %s", $time, what);
        error_count++;
    endtask

    task automatic send_access(input action_t act, input key_t k, input val_t v);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.key    <= k;
        req_ch.value  <= v;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        pending_q = {pending_q, predict_access(act, k, v)};
    endtask

    // Drop valid, drain all responses, then idle before returning.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input cap_t c);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cap_setting = c;
    endtask

    task automatic test_basic_access();
        send_access(ACT_GET, '0, '1);
        send_access(ACT_SET, KEY_MIN, VAL_MAX);
        send_access(ACT_GET, KEY_MIN, '0);
        send_access(ACT_SET, KEY_MAX, VAL_MIN);
        send_access(ACT_SET, '1, '0);
        send_access(ACT_SET, '0, '1);
        send_access(ACT_GET, KEY_MAX, '1);
        send_access(ACT_GET, '1, '0);
        send_access(ACT_GET, '0, '0);
        // update in place
        send_access(ACT_SET, KEY_MIN, 32'sh5A5A_A5A5);
        send_access(ACT_GET, KEY_MIN, '0);
        send_access(ACT_GET, 32'sh1234_5678, '0);
    endtask

    task automatic test_lru_order();
        key_t ka;
        key_t kb;
        key_t kc;
        ka = key_t'($urandom);
        kb = key_t'($urandom);
        kc = key_t'($urandom);
        write_capacity(5'd2);
        send_access(ACT_SET, ka, val_t'($urandom));
        send_access(ACT_SET, kb, val_t'($urandom));
        send_access(ACT_GET, ka, '0);
        // kb is now less recent than ka, but an older entry goes out first
        send_access(ACT_SET, kc, val_t'($urandom));
        send_access(ACT_GET, kb, '0);
        send_access(ACT_GET, ka, '0);
        send_access(ACT_GET, kc, '0);
    endtask

    task automatic test_capacity_zero();
        key_t kx;
        key_t ky;
        kx = key_t'($urandom);
        ky = key_t'($urandom);
        write_capacity(5'd0);
        send_access(ACT_SET, kx, val_t'($urandom));
        send_access(ACT_SET, ky, val_t'($urandom));
        send_access(ACT_GET, kx, '0);
        send_access(ACT_GET, ky, '0);
    endtask

    task automatic test_capacity_shrink();
        key_t ks [8];
        int   i;
        for (i = 0; i < 8; i++)
            ks[i] = key_t'($urandom);
        write_capacity(CAP_TOP);
        for (i = 0; i < 8; i++)
            send_access(ACT_SET, ks[i], val_t'($urandom));
        // Lower below the live count; each insert evicts one entry only.
        write_capacity(5'd3);
        send_access(ACT_SET, key_t'($urandom), val_t'($urandom));
        send_access(ACT_GET, ks[0], '0);
        send_access(ACT_GET, ks[1], '0);
        send_access(ACT_GET, ks[7], '0);
    endtask

    task automatic test_output_backpressure();
        idle_on  = 1'b0;
        rsp_hold = 400;
        repeat (16)
            send_access(action_t'($urandom_range(0, 1)), pick_key(), val_t'($urandom));
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        cap_t caps [8];
        int   p;
        int   i;
        int   room;
        caps = '{5'd16, 5'd1, CAP_TOP, 5'd4, 5'd0, 5'd9, 5'd17, 5'd2};
        for (p = 0; p < 8; p++)
        begin
            write_capacity(caps[p]);
            room = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : int'(caps[p]);
            pool_size = (room + 4 > POOL_MAX) ? POOL_MAX : room + 4;
            for (i = 0; i < pool_size; i++)
                key_pool[i] = key_t'($urandom);
            idle_on = (p != 3);
            repeat (PHASE_ITEMS)
                send_access(action_t'($urandom_range(0, 1)), pick_key(), val_t'($urandom));
        end
        idle_on = 1'b1;
    endtask

    // Response side: random stalls plus the long hold-off on request
    initial
    begin
        int gap_left;
        gap_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold--;
            end
            else if (gap_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_q.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                want = pending_q.pop_front();
                if (rsp_ch.found !== want.found)
                    report_mismatch($sformatf("found %b, expected %b",
                                              rsp_ch.found, want.found));
                if (rsp_ch.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, expected %h",
                                              rsp_ch.read_value, want.read_value));
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= CAP_RESET;
        req_ch.valid  <= 1'b0;
        req_ch.action <= ACT_GET;
        req_ch.key    <= '0;
        req_ch.value  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_access();
        test_lru_order();
        test_capacity_zero();
        test_capacity_shrink();
        test_output_backpressure();
        test_random_traffic();

        settle_block();
        if (error_count == 0)
            $display("tb_lru_key_value_cache: PASS");
        else
            $display("tb_lru_key_value_cache: FAIL");
        $finish;
    end

endmodule
